FILE: design/rolling_hash_pattern_counter_top_assert.svh
// Assertion macros for the rolling hash pattern counter.
`ifndef ROLLING_HASH_PATTERN_COUNTER_TOP_ASSERT_SVH
`define ROLLING_HASH_PATTERN_COUNTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RHPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhpc: same-cycle check failed");
// next-cycle implication
`define RHPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhpc: next-cycle check failed");
`else
`define RHPC_ASSERT_IMP(lbl, ante, cons)
`define RHPC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: design/rhpc_pkg.sv
// Shared types, constants and reduction tables for the rolling hash pattern counter.
package rhpc_pkg;

  localparam int HASH_W = 30;
  localparam logic [HASH_W-1:0] HASH_MOD = 30'd1000000009;
  localparam longint unsigned HASH_MOD_L = 64'd1000000009;
  localparam int MAX_PATTERN_DEF = 64;
  localparam int COUNT_W = 24;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int OUT_W = 32;
  localparam int PROD_W = 38;
  localparam logic [BYTE_W-1:0] LETTER_BIAS = 8'd96;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_TEXT    = 2'd2
  } kind_t;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic clr;      // clear everything
    logic restart;  // pattern letter: text side restarts
    logic pat_add;  // pattern letter accepted into hash
    logic text;     // text letter
    logic check;    // full window present, compare
    logic first;    // first full window, no ring read
    logic ovf;      // overflow flag after this item
  } ctl_t;

  // quotient tables: floor(hi * 2^k / M) for the top 8 bits of a product
  typedef logic [255:0][8:0] qprod_tab_t;
  typedef logic [255:0][5:0] q31_tab_t;

  function automatic qprod_tab_t build_qprod();
    qprod_tab_t tab;
    tab = '0;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 9'((longint'(i) << 30) / HASH_MOD_L);
    end
    return tab;
  endfunction

  function automatic q31_tab_t build_q31();
    q31_tab_t tab;
    tab = '0;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 6'((longint'(i) << 27) / HASH_MOD_L);
    end
    return tab;
  endfunction

  localparam qprod_tab_t Q_PROD = build_qprod();
  localparam q31_tab_t Q_MUL31 = build_q31();

endpackage

FILE: design/rolling_hash_pattern_counter_top.sv
// Top level of the rolling hash pattern counter.
//
// Counts occurrences of one pattern in a letter stream with a polynomial
// rolling hash (base 31, modulus 1e9+9, letter value = byte - 96). Each input
// item carries a kind in in_tuser (clear, pattern letter, text letter) and the
// letter byte in in_tdata; every item yields exactly one result item with the
// match bit, the saturating 24-bit match total and the pattern overflow flag.
// Sustained rate is one item per clock when nothing stalls. The pipeline is:
// accept stage (power sequencing, ring addressing), product, two reduction
// stages, accumulation with the prefix ring access, window compare, output
// register. The recurrences that bound the rate (powers times 31, prefix and
// pattern hash sums, scaled pattern hash, match count) are each a register
// fed back through combinational logic, and the prefix ring takes one read
// and one write per cycle. Ring depth equals MAX_PATTERN; ring contents after
// reset are undefined and need no clearing pass, since an entry is read only
// after this run wrote it. Each stage holds when its successor is full; a
// waiting result lets five more items in before in_tready drops.
// Patterns longer than MAX_PATTERN set the overflow flag and disable matching
// until a clear item. Hash collisions count as matches.
`include "rolling_hash_pattern_counter_top_assert.svh"

module rolling_hash_pattern_counter_top #(
  parameter int MAX_PATTERN = rhpc_pkg::MAX_PATTERN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rhpc_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] letter_byte
  input  logic [rhpc_pkg::KIND_W-1:0]   in_tuser,   // [1:0] kind
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rhpc_pkg::OUT_W-1:0]    out_tdata   // [0] match, [24:1] match_total,
                                                    // [25] pattern_overflow, [31:26] zero
);

  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PAD_W  = rhpc_pkg::OUT_W - rhpc_pkg::COUNT_W - 2;

  // accept stage -> term pipeline
  logic                          f_valid, f_ready;
  rhpc_pkg::ctl_t                f_ctl;
  logic [rhpc_pkg::BYTE_W-1:0]   f_mag;
  logic                          f_neg;
  logic [rhpc_pkg::HASH_W-1:0]   f_power;
  logic [ADDR_W-1:0]             f_wr_addr, f_rd_addr;

  // term pipeline -> accumulate/compare
  logic                          t_valid, t_ready;
  rhpc_pkg::ctl_t                t_ctl;
  logic [rhpc_pkg::HASH_W-1:0]   t_term;
  logic [ADDR_W-1:0]             t_wr_addr, t_rd_addr;

  // result fields
  logic                          res_match, res_ovf;
  logic [rhpc_pkg::COUNT_W-1:0]  res_total;

  rhpc_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_byte   (in_tdata),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_ctl     (f_ctl),
    .f_mag     (f_mag),
    .f_neg     (f_neg),
    .f_power   (f_power),
    .f_wr_addr (f_wr_addr),
    .f_rd_addr (f_rd_addr)
  );

  rhpc_term #(
    .ADDR_W (ADDR_W)
  ) u_term (
    .clk       (clk),
    .rst_n     (rst_n),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_ctl     (f_ctl),
    .f_mag     (f_mag),
    .f_neg     (f_neg),
    .f_power   (f_power),
    .f_wr_addr (f_wr_addr),
    .f_rd_addr (f_rd_addr),
    .t_valid   (t_valid),
    .t_ready   (t_ready),
    .t_ctl     (t_ctl),
    .t_term    (t_term),
    .t_wr_addr (t_wr_addr),
    .t_rd_addr (t_rd_addr)
  );

  rhpc_match #(
    .MAX_PATTERN (MAX_PATTERN),
    .ADDR_W      (ADDR_W)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .t_valid   (t_valid),
    .t_ready   (t_ready),
    .t_ctl     (t_ctl),
    .t_term    (t_term),
    .t_wr_addr (t_wr_addr),
    .t_rd_addr (t_rd_addr),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_match (res_match),
    .out_total (res_total),
    .out_ovf   (res_ovf)
  );

  assign out_tdata = {{PAD_W{1'b0}}, res_ovf, res_total, res_match};

  // a compare is only scheduled for a text letter with matching enabled
  `RHPC_ASSERT_IMP(a_check_text, f_valid && f_ctl.check, f_ctl.text && !f_ctl.ovf)
  // the first full window is always a compare
  `RHPC_ASSERT_IMP(a_first_check, f_valid && f_ctl.first, f_ctl.check)
  // a reported match is always counted
  `RHPC_ASSERT_IMP(a_match_counted, out_tvalid && out_tdata[0], out_tdata[24:1] != '0)
  // an accepted clear lands in the accept stage as a clear
  `RHPC_ASSERT_NXT(a_clear_taken,
                   in_tvalid && in_tready && (in_tuser == rhpc_pkg::KIND_CLEAR),
                   f_valid && f_ctl.clr)

endmodule

FILE: design/rhpc_mul31.sv
// Multiply by 31 modulo the hash modulus, table-assisted combinational reduction.
module rhpc_mul31 (
  input  logic [rhpc_pkg::HASH_W-1:0] a,
  output logic [rhpc_pkg::HASH_W-1:0] y
);

  logic [34:0] x;
  logic [5:0]  q;
  logic [34:0] qm;
  logic [34:0] r;

  always_comb begin
    x  = {a, 5'b0} - {5'b0, a};
    q  = rhpc_pkg::Q_MUL31[x[34:27]];
    qm = 35'(q) * 35'(rhpc_pkg::HASH_MOD);
    r  = x - qm;  // below 2M
    if (r >= 35'(rhpc_pkg::HASH_MOD)) begin
      y = rhpc_pkg::HASH_W'(r - 35'(rhpc_pkg::HASH_MOD));
    end else begin
      y = rhpc_pkg::HASH_W'(r);
    end
  end

endmodule

FILE: design/rhpc_ring.sv
// Prefix hash ring: one write port, one registered read port.
module rhpc_ring #(
  parameter int DEPTH  = rhpc_pkg::MAX_PATTERN_DEF,
  parameter int ADDR_W = 6
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [rhpc_pkg::HASH_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [rhpc_pkg::HASH_W-1:0] rd_data
);

  logic [rhpc_pkg::HASH_W-1:0] mem [DEPTH];
  logic [rhpc_pkg::HASH_W-1:0] rd_data_r;

  // read-before-write on a shared address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/rhpc_front.sv
// Input stage: letter decode, power sequencing, window and ring address control.
module rhpc_front #(
  parameter int MAX_PATTERN = rhpc_pkg::MAX_PATTERN_DEF,
  parameter int LEN_W       = 7,
  parameter int ADDR_W      = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rhpc_pkg::KIND_W-1:0]   in_kind,
  input  logic [rhpc_pkg::BYTE_W-1:0]   in_byte,
  output logic                          f_valid,
  input  logic                          f_ready,
  output rhpc_pkg::ctl_t                f_ctl,
  output logic [rhpc_pkg::BYTE_W-1:0]   f_mag,
  output logic                          f_neg,
  output logic [rhpc_pkg::HASH_W-1:0]   f_power,
  output logic [ADDR_W-1:0]             f_wr_addr,
  output logic [ADDR_W-1:0]             f_rd_addr
);

  localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_PATTERN);
  localparam logic [LEN_W:0]   MAX_X = (LEN_W+1)'(MAX_PATTERN);
  localparam logic [ADDR_W-1:0] POS_LAST = ADDR_W'(MAX_PATTERN - 1);
  localparam logic [rhpc_pkg::HASH_W-1:0] ONE = rhpc_pkg::HASH_W'(1);

  logic [LEN_W-1:0]            plen_r, plen_nxt;
  logic [LEN_W-1:0]            seen_r, seen_nxt;
  logic [ADDR_W-1:0]           pos_r, pos_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [rhpc_pkg::HASH_W-1:0] tp_r, tp_nxt;
  logic [rhpc_pkg::HASH_W-1:0] pp_r, pp_nxt;
  logic [rhpc_pkg::HASH_W-1:0] tp31, pp31;

  logic                        f_valid_r;
  rhpc_pkg::ctl_t              f_ctl_r, ctl;
  logic [rhpc_pkg::BYTE_W-1:0] f_mag_r, mag;
  logic                        f_neg_r, neg;
  logic [rhpc_pkg::HASH_W-1:0] f_power_r, power;
  logic [ADDR_W-1:0]           f_wr_addr_r, f_rd_addr_r, rd_addr;

  logic                        acc;
  logic                        active;
  logic [LEN_W:0]              seen_p1, m_ext, rd_sum, rd_wrap;
  rhpc_pkg::kind_t             kind;

  rhpc_mul31 u_tp31 (.a(tp_r), .y(tp31));
  rhpc_mul31 u_pp31 (.a(pp_r), .y(pp31));

  assign in_ready = !f_valid_r || f_ready;
  assign acc      = in_valid && in_ready;

  // letter value as sign and magnitude: byte - 96
  always_comb begin
    neg = in_byte < rhpc_pkg::LETTER_BIAS;
    mag = neg ? (rhpc_pkg::LETTER_BIAS - in_byte) : (in_byte - rhpc_pkg::LETTER_BIAS);
  end

  always_comb begin
    kind     = rhpc_pkg::kind_t'(in_kind);
    plen_nxt = plen_r;
    seen_nxt = seen_r;
    pos_nxt  = pos_r;
    ovf_nxt  = ovf_r;
    tp_nxt   = tp_r;
    pp_nxt   = pp_r;
    ctl      = '0;
    power    = tp_r;
    active   = (plen_r != '0) && !ovf_r;
    seen_p1  = (LEN_W+1)'(seen_r) + 1'b1;
    m_ext    = (LEN_W+1)'(plen_r);
    // window start slot: pos - m modulo ring depth
    rd_sum   = (LEN_W+1)'(pos_r) + MAX_X - m_ext;
    rd_wrap  = (rd_sum >= MAX_X) ? (rd_sum - MAX_X) : rd_sum;
    rd_addr  = rd_wrap[ADDR_W-1:0];
    unique case (kind)
      rhpc_pkg::KIND_CLEAR: begin
        plen_nxt = '0;
        seen_nxt = '0;
        pos_nxt  = '0;
        ovf_nxt  = 1'b0;
        tp_nxt   = ONE;
        pp_nxt   = ONE;
        ctl.clr  = 1'b1;
      end
      rhpc_pkg::KIND_PATTERN: begin
        ctl.restart = 1'b1;
        power       = pp_r;
        if (plen_r >= MAX_L) begin
          ovf_nxt = 1'b1;
        end else begin
          ctl.pat_add = 1'b1;
          plen_nxt    = plen_r + 1'b1;
          pp_nxt      = pp31;
        end
        tp_nxt   = ONE;
        seen_nxt = '0;
        pos_nxt  = '0;
      end
      rhpc_pkg::KIND_TEXT: begin
        ctl.text  = 1'b1;
        ctl.check = active && (seen_p1 >= m_ext);
        ctl.first = active && (seen_p1 == m_ext);
        tp_nxt    = tp31;
        if (seen_r < MAX_L) begin
          seen_nxt = seen_r + 1'b1;
        end
        pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
      end
      default: begin
      end
    endcase
    ctl.ovf = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
      seen_r <= '0;
      pos_r  <= '0;
      ovf_r  <= 1'b0;
      tp_r   <= ONE;
      pp_r   <= ONE;
    end else if (acc) begin
      plen_r <= plen_nxt;
      seen_r <= seen_nxt;
      pos_r  <= pos_nxt;
      ovf_r  <= ovf_nxt;
      tp_r   <= tp_nxt;
      pp_r   <= pp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_ready) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      f_ctl_r     <= ctl;
      f_mag_r     <= mag;
      f_neg_r     <= neg;
      f_power_r   <= power;
      f_wr_addr_r <= pos_r;
      f_rd_addr_r <= rd_addr;
    end
  end

  assign f_valid   = f_valid_r;
  assign f_ctl     = f_ctl_r;
  assign f_mag     = f_mag_r;
  assign f_neg     = f_neg_r;
  assign f_power   = f_power_r;
  assign f_wr_addr = f_wr_addr_r;
  assign f_rd_addr = f_rd_addr_r;

endmodule

FILE: design/rhpc_term.sv
// Weighted letter term: multiply, two-step modular reduction, sign fix.
module rhpc_term #(
  parameter int ADDR_W = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          f_valid,
  output logic                          f_ready,
  input  rhpc_pkg::ctl_t                f_ctl,
  input  logic [rhpc_pkg::BYTE_W-1:0]   f_mag,
  input  logic                          f_neg,
  input  logic [rhpc_pkg::HASH_W-1:0]   f_power,
  input  logic [ADDR_W-1:0]             f_wr_addr,
  input  logic [ADDR_W-1:0]             f_rd_addr,
  output logic                          t_valid,
  input  logic                          t_ready,
  output rhpc_pkg::ctl_t                t_ctl,
  output logic [rhpc_pkg::HASH_W-1:0]   t_term,
  output logic [ADDR_W-1:0]             t_wr_addr,
  output logic [ADDR_W-1:0]             t_rd_addr
);

  localparam int W = rhpc_pkg::HASH_W;
  localparam int PW = rhpc_pkg::PROD_W;
  localparam logic [W:0] MOD1 = {1'b0, rhpc_pkg::HASH_MOD};
  localparam logic [W:0] MOD2 = {rhpc_pkg::HASH_MOD, 1'b0};

  // stage 2: raw product
  logic                 v2_r;
  rhpc_pkg::ctl_t       c2_r;
  logic                 n2_r;
  logic [PW-1:0]        prod_r;
  logic [ADDR_W-1:0]    wa2_r, ra2_r;
  // stage 3: partly reduced, below about 2.07 M
  logic                 v3_r;
  rhpc_pkg::ctl_t       c3_r;
  logic                 n3_r;
  logic [W:0]           r1_r;
  logic [ADDR_W-1:0]    wa3_r, ra3_r;
  // stage 4: final term
  logic                 v4_r;
  rhpc_pkg::ctl_t       c4_r;
  logic [W-1:0]         term_r;
  logic [ADDR_W-1:0]    wa4_r, ra4_r;

  logic                 rdy2, rdy3, rdy4;
  logic [PW-1:0]        prod;
  logic [8:0]           q;
  logic [PW-1:0]        qm;
  logic [W:0]           r1;
  logic [W-1:0]         r2, term;

  assign rdy4    = !v4_r || t_ready;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign f_ready = rdy2;

  always_comb begin
    prod = PW'(f_mag) * PW'(f_power);
    q    = rhpc_pkg::Q_PROD[prod_r[PW-1:W]];
    qm   = PW'(q) * PW'(rhpc_pkg::HASH_MOD);
    r1   = (W+1)'(prod_r - qm);
    if (r1_r >= MOD2) begin
      r2 = W'(r1_r - MOD2);
    end else if (r1_r >= MOD1) begin
      r2 = W'(r1_r - MOD1);
    end else begin
      r2 = W'(r1_r);
    end
    // negative letters: M - r unless zero
    term = (n3_r && (r2 != '0)) ? (rhpc_pkg::HASH_MOD - r2) : r2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_r <= f_valid;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      c2_r   <= f_ctl;
      n2_r   <= f_neg;
      prod_r <= prod;
      wa2_r  <= f_wr_addr;
      ra2_r  <= f_rd_addr;
    end
    if (rdy3) begin
      c3_r  <= c2_r;
      n3_r  <= n2_r;
      r1_r  <= r1;
      wa3_r <= wa2_r;
      ra3_r <= ra2_r;
    end
    if (rdy4) begin
      c4_r   <= c3_r;
      term_r <= term;
      wa4_r  <= wa3_r;
      ra4_r  <= ra3_r;
    end
  end

  assign t_valid   = v4_r;
  assign t_ctl     = c4_r;
  assign t_term    = term_r;
  assign t_wr_addr = wa4_r;
  assign t_rd_addr = ra4_r;

endmodule

FILE: design/rhpc_match.sv
// Hash accumulation, prefix ring access, window compare and match count.
module rhpc_match #(
  parameter int MAX_PATTERN = rhpc_pkg::MAX_PATTERN_DEF,
  parameter int ADDR_W      = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           t_valid,
  output logic                           t_ready,
  input  rhpc_pkg::ctl_t                 t_ctl,
  input  logic [rhpc_pkg::HASH_W-1:0]    t_term,
  input  logic [ADDR_W-1:0]              t_wr_addr,
  input  logic [ADDR_W-1:0]              t_rd_addr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_match,
  output logic [rhpc_pkg::COUNT_W-1:0]   out_total,
  output logic                           out_ovf
);

  localparam int W = rhpc_pkg::HASH_W;

  function automatic logic [W-1:0] addmod(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    addmod = (s >= {1'b0, rhpc_pkg::HASH_MOD}) ? W'(s - {1'b0, rhpc_pkg::HASH_MOD}) : W'(s);
  endfunction

  // running state, updated in item order at stage 4
  logic [W-1:0] ph_r, ph_nxt;
  logic [W-1:0] prefix_r, prefix_nxt;
  logic [W-1:0] scaled_r, scaled_nxt;
  logic [W-1:0] prefix_new, ph_add, scl31;

  // stage 5
  logic           v5_r;
  rhpc_pkg::ctl_t c5_r;
  logic [W-1:0]   pre5_r, scl5_r;
  logic [W-1:0]   old;

  // output register
  logic                         ov_r, om_r, oo_r;
  logic [rhpc_pkg::COUNT_W-1:0] ot_r;
  logic [rhpc_pkg::COUNT_W-1:0] count_r, count_nxt;

  logic         rdy_o, adv4, adv5;
  logic         wr_en, rd_en;
  logic [W:0]   d;
  logic [W-1:0] diff, cmp;
  logic         hit;

  assign rdy_o   = !ov_r || out_ready;
  assign t_ready = !v5_r || rdy_o;
  assign adv4    = t_valid && t_ready;
  assign adv5    = v5_r && rdy_o;

  rhpc_mul31 u_scl31 (.a(scaled_r), .y(scl31));

  always_comb begin
    prefix_new = addmod(prefix_r, t_term);
    ph_add     = addmod(ph_r, t_term);
    ph_nxt     = ph_r;
    prefix_nxt = prefix_r;
    scaled_nxt = scaled_r;
    if (t_ctl.clr) begin
      ph_nxt     = '0;
      prefix_nxt = '0;
      scaled_nxt = '0;
    end else if (t_ctl.restart) begin
      if (t_ctl.pat_add) begin
        ph_nxt = ph_add;
      end
      prefix_nxt = '0;
      scaled_nxt = '0;
    end else if (t_ctl.text) begin
      prefix_nxt = prefix_new;
      if (t_ctl.check) begin
        scaled_nxt = t_ctl.first ? ph_r : scl31;
      end
    end
  end

  // The item at stage 4 reads its window start and writes its own prefix in the
  // same cycle; for a full-depth window both hit one slot and the old value is read.
  assign wr_en = adv4 && t_ctl.text;
  assign rd_en = adv4 && t_ctl.check && !t_ctl.first;

  rhpc_ring #(
    .DEPTH  (MAX_PATTERN),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (t_wr_addr),
    .wr_data (prefix_new),
    .rd_en   (rd_en),
    .rd_addr (t_rd_addr),
    .rd_data (old)
  );

  always_comb begin
    d    = {1'b0, pre5_r} - {1'b0, old};
    diff = d[W] ? W'(d + {1'b0, rhpc_pkg::HASH_MOD}) : W'(d);
    cmp  = c5_r.first ? pre5_r : diff;
    hit  = c5_r.check && (cmp == scl5_r);
    if (c5_r.clr) begin
      count_nxt = '0;
    end else if (hit && (count_r != '1)) begin
      count_nxt = count_r + 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= '0;
      prefix_r <= '0;
      scaled_r <= '0;
    end else if (adv4) begin
      ph_r     <= ph_nxt;
      prefix_r <= prefix_nxt;
      scaled_r <= scaled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r    <= 1'b0;
      ov_r    <= 1'b0;
      count_r <= '0;
    end else begin
      if (t_ready) begin
        v5_r <= t_valid;
      end
      if (rdy_o) begin
        ov_r <= v5_r;
      end
      if (adv5) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (t_ready) begin
      c5_r   <= t_ctl;
      pre5_r <= prefix_new;
      scl5_r <= scaled_nxt;
    end
    if (rdy_o) begin
      om_r <= hit;
      ot_r <= count_nxt;
      oo_r <= c5_r.ovf;
    end
  end

  assign out_valid = ov_r;
  assign out_match = om_r;
  assign out_total = ot_r;
  assign out_ovf   = oo_r;

endmodule

FILE: verif/rolling_hash_pattern_counter_checker.sv
// Scoreboard: predicts every result item of the pattern counter and checks it.
`timescale 1ns / 100ps

module rolling_hash_pattern_counter_checker
  import rhpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,    // [7:0] letter_byte
  input  logic [KIND_W-1:0] in_tuser,    // [1:0] kind
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,   // [0] match, [24:1] match_total, [25] overflow
  output int                fail_count,
  output int                pending
);

  localparam int MAX_LEN = MAX_PATTERN_DEF;   // ring depth equals the longest pattern
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
  localparam logic [HASH_W-1:0] BASE = 30'd31;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic               match;
    logic [COUNT_W-1:0] total;
    logic               ovf;
  } tally_t;

  logic [HASH_W-1:0]  pat_hash, pat_power, txt_power, prefix_now, scaled_hash;
  logic [HASH_W-1:0]  prefix_ring [MAX_LEN];
  int unsigned        pat_len, txt_seen, ring_wr;
  logic [COUNT_W-1:0] hit_count;
  logic               ovf_seen;
  tally_t             tallies_due[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [HASH_W-1:0] mod_mul(logic [HASH_W-1:0] a, logic [HASH_W-1:0] b);
    longint unsigned p;
    p = a;
    p = p * b;
    return HASH_W'(p % HASH_MOD_L);
  endfunction

  function automatic logic [HASH_W-1:0] mod_add(logic [HASH_W-1:0] a, logic [HASH_W-1:0] b);
    longint unsigned s;
    s = a;
    s = s + b;
    if (s >= HASH_MOD_L) s = s - HASH_MOD_L;
    return HASH_W'(s);
  endfunction

  // byte - 96, wrapped into the field for bytes below the bias
  function automatic logic [HASH_W-1:0] letter_value(logic [BYTE_W-1:0] b);
    longint unsigned v;
    v = b;
    if (b < LETTER_BIAS) v = v + HASH_MOD_L;
    return HASH_W'(v - LETTER_BIAS);
  endfunction

  function automatic void restart_text_side();
    txt_power = HASH_W'(1);
    prefix_now = '0;
    txt_seen = 0;
    scaled_hash = '0;
    ring_wr = 0;
  endfunction

  // ring entries are only read after being written, so no clearing needed
  function automatic void clear_all();
    pat_hash = '0;
    pat_len = 0;
    pat_power = HASH_W'(1);
    hit_count = '0;
    ovf_seen = 1'b0;
    restart_text_side();
  endfunction

  function automatic tally_t count_window_hits(logic [KIND_W-1:0] kind,
                                               logic [BYTE_W-1:0] b);
    tally_t            t;
    logic [HASH_W-1:0] v, prefix, old, window;
    longint unsigned   w;
    t = '0;
    v = letter_value(b);
    case (kind)
      KIND_CLEAR: clear_all();
      KIND_PATTERN: begin
        if (pat_len >= MAX_LEN) begin
          ovf_seen = 1'b1;
        end else begin
          pat_hash = mod_add(pat_hash, mod_mul(v, pat_power));
          pat_power = mod_mul(pat_power, BASE);
          pat_len++;
        end
        restart_text_side();
      end
      KIND_TEXT: begin
        prefix = mod_add(prefix_now, mod_mul(v, txt_power));
        if (pat_len != 0 && !ovf_seen && txt_seen + 1 >= pat_len) begin
          window = prefix;
          if (txt_seen == pat_len - 1) begin
            scaled_hash = pat_hash;
          end else begin
            old = prefix_ring[(ring_wr + MAX_LEN - pat_len) % MAX_LEN];
            w = prefix;
            w = w + HASH_MOD_L - old;
            if (w >= HASH_MOD_L) w = w - HASH_MOD_L;
            window = HASH_W'(w);
            scaled_hash = mod_mul(scaled_hash, BASE);
          end
          if (window == scaled_hash) begin
            t.match = 1'b1;
            if (hit_count != COUNT_TOP) hit_count++;
          end
        end
        prefix_ring[ring_wr] = prefix;
        prefix_now = prefix;
        ring_wr = (ring_wr + 1) % MAX_LEN;
        txt_power = mod_mul(txt_power, BASE);
        if (txt_seen < MAX_LEN) txt_seen++;
      end
      default: ;
    endcase
    t.total = hit_count;
    t.ovf = ovf_seen;
    return t;
  endfunction

  task automatic log_failure(string what);
    if (fail_count < PRINT_CAP) $display("%0t rhpc check: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin : track
    tally_t want;
    if (!rst_n) begin
      clear_all();
      tallies_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (tallies_due.size() == 0) begin
          log_failure($sformatf("result %h with nothing due", out_tdata));
        end else begin
          want = tallies_due.pop_front();
          if (out_tdata[0] !== want.match)
            log_failure($sformatf("match %b, want %b", out_tdata[0], want.match));
          if (out_tdata[24:1] !== want.total)
            log_failure($sformatf("match_total %0d, want %0d", out_tdata[24:1], want.total));
          if (out_tdata[25] !== want.ovf)
            log_failure($sformatf("pattern_overflow %b, want %b", out_tdata[25], want.ovf));
          if (out_tdata[OUT_W-1:26] !== '0)
            log_failure($sformatf("pad bits %b, want zero", out_tdata[OUT_W-1:26]));
        end
      end
      if (in_tvalid && in_tready) tallies_due.push_back(count_window_hits(in_tuser, in_tdata));
    end
    pending <= tallies_due.size();
  end

endmodule

FILE: verif/rolling_hash_pattern_counter_top_test.sv
// Testbench top: clock, reset, stimulus, output back-pressure and verdict.
`timescale 1ns / 100ps

module rolling_hash_pattern_counter_top_test;
  import rhpc_pkg::*;

  // kind 3 is not decoded by the block; it must leave the state alone
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int ITEM_GOAL = 1600;
  // no handshake on either side for this long means the block is stuck
  localparam int IDLE_LIMIT = 2000;
  // settling time after the scoreboard has drained, before the verdict
  localparam int SETTLE_CYCLES = 16;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata;    // [7:0] letter_byte
  logic [KIND_W-1:0] in_tuser;    // [1:0] kind
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;   // [0] match, [24:1] match_total, [25] overflow
  int                fail_count;
  int                pending;

  int items_sent  = 0;   // letters and clears; unused kinds do not count
  int send_calm   = 0;   // items left in a no-gap stretch on the input side
  int drain_calm  = 0;   // cycles left in an always-ready stretch on the output side
  int drain_stall = 0;   // cycles left in an output stall
  int idle_cycles = 0;

  logic [BYTE_W-1:0] alphabet[$];    // letters of the current random sequence
  logic [BYTE_W-1:0] pat_bytes[$];   // pattern as sent, copied into the text for hits

  rolling_hash_pattern_counter_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  rolling_hash_pattern_counter_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Output back-pressure: mostly ready with short stalls, a few long stalls,
  // and occasional long stretches with no stall at all.
  always @(posedge clk) begin : drain
    int r;
    if (drain_calm > 0) begin
      drain_calm--;
      out_tready <= 1'b1;
    end else if (drain_stall > 0) begin
      drain_stall--;
      out_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        drain_calm = $urandom_range(40, 250);
        out_tready <= 1'b1;
      end else if (r < 5) begin
        drain_stall = $urandom_range(8, 40);
        out_tready <= 1'b0;
      end else if (r < 30) begin
        drain_stall = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: any accepted item on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("rolling_hash_pattern_counter_top_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one item and hold it until accepted. A random gap goes first,
  // so idle cycles land on every phase of the pipeline.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] letter);
    int gap, r;
    gap = 0;
    if (send_calm > 0) begin
      send_calm--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) send_calm = $urandom_range(30, 200);
      else if (r < 6) gap = $urandom_range(8, 30);
      else if (r < 35) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= letter;
    do @(posedge clk); while (!in_tready);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  // Stop sending until the scoreboard has nothing outstanding.
  // pending is registered from the handshakes, hence the first wait.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Text of about n letters: whole copies of the pattern mixed with random
  // letters of the same small alphabet, so hits and near misses are common.
  task automatic send_text(int n);
    int i;
    i = 0;
    while (i < n) begin
      if (pat_bytes.size() != 0 && $urandom_range(0, 99) < 35) begin
        foreach (pat_bytes[j]) send_item(KIND_TEXT, pat_bytes[j]);
        i += pat_bytes.size();
      end else begin
        if ($urandom_range(0, 99) < 4) send_item(KIND_UNUSED, 8'($urandom));
        send_item(KIND_TEXT, alphabet[$urandom_range(0, alphabet.size() - 1)]);
        i++;
      end
    end
  endtask

  initial begin
    int                seq_no, r, plen, tlen;
    logic [BYTE_W-1:0] b;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_CLEAR;
    out_tready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    send_item(KIND_CLEAR, 8'h00);
    send_item(KIND_TEXT, 8'd97);          // empty pattern: never a hit
    send_item(KIND_UNUSED, 8'hFF);        // undecoded kind, state untouched
    send_item(KIND_PATTERN, 8'd97);
    send_item(KIND_PATTERN, 8'h00);       // byte below the bias wraps
    repeat (2) begin
      send_item(KIND_TEXT, 8'd97);
      send_item(KIND_TEXT, 8'h00);        // overlapping windows, ring reads
    end
    send_item(KIND_TEXT, 8'hFF);
    send_item(KIND_PATTERN, 8'hFF);       // pattern grows after text: text restarts
    repeat (2) begin
      send_item(KIND_TEXT, 8'd97);
      send_item(KIND_TEXT, 8'h00);
      send_item(KIND_TEXT, 8'hFF);
    end
    send_item(KIND_UNUSED, 8'h00);
    send_item(KIND_CLEAR, 8'hFF);         // count and flag back to zero
    send_item(KIND_PATTERN, LETTER_BIAS); // letter value zero, pattern hash zero
    send_item(KIND_TEXT, LETTER_BIAS);
    send_item(KIND_TEXT, LETTER_BIAS - 8'd1);
    wait_drained();

    // ---- random part ----
    // Mostly well-formed runs: clear, pattern, text with embedded copies,
    // sometimes a pattern extension mid-text. Patterns are mostly short;
    // a few fill the ring or run past it to raise the overflow flag.
    // The rest is noise with random kinds and bytes.
    seq_no = 0;
    while (items_sent < ITEM_GOAL) begin
      seq_no++;
      if (seq_no % 10 == 0) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 18) begin
        repeat ($urandom_range(4, 14))
          send_item(KIND_W'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        if ($urandom_range(0, 99) < 75) send_item(KIND_CLEAR, 8'($urandom));
        alphabet.delete();
        repeat ($urandom_range(1, 3)) alphabet.push_back(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 6) begin
          plen = $urandom_range(62, 70);
          tlen = $urandom_range(70, 150);
        end else if (r < 14) begin
          plen = $urandom_range(20, 61);
          tlen = $urandom_range(40, 100);
        end else begin
          plen = $urandom_range(1, 6);
          tlen = $urandom_range(8, 40);
        end
        pat_bytes.delete();
        repeat (plen) begin
          b = alphabet[$urandom_range(0, alphabet.size() - 1)];
          pat_bytes.push_back(b);
          send_item(KIND_PATTERN, b);
        end
        send_text(tlen);
        if ($urandom_range(0, 99) < 25) begin
          repeat ($urandom_range(1, 3)) begin
            b = alphabet[$urandom_range(0, alphabet.size() - 1)];
            pat_bytes.push_back(b);
            send_item(KIND_PATTERN, b);
          end
          send_text($urandom_range(8, 30));
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("rolling_hash_pattern_counter_top_test: clean");
    end else begin
      $display("rolling_hash_pattern_counter_top_test: errors");
    end
    $finish;
  end

endmodule
